// ===== design/spq_pkg.sv =====
`timescale 1ns / 1ps

package spq_pkg;

    localparam int CAPACITY = 512;
    localparam int TAG_BITS = 16;

    localparam int ADDR_W  = $clog2(CAPACITY);
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int CHILD_W = CNT_W + 1;
    localparam int TAG_W   = (TAG_BITS < 16) ? TAG_BITS : 16;

    localparam logic       KIND_PUSH = 1'b0;
    localparam logic       KIND_POP  = 1'b1;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic        kind;
        logic [31:0] in_priority;
        logic [15:0] item_tag;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] popped_item;
        logic [31:0] popped_priority;
        logic        front_valid;
        logic [15:0] front_item;
        logic [31:0] front_priority;
        logic [9:0]  entry_count;
    } t_out_beat;

    typedef struct packed {
        logic [31:0]      prio;
        logic [TAG_W-1:0] tag;
        logic [31:0]      order;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic               we;
        logic [ADDR_W-1:0]  wr_addr;
        t_entry             wr_data;
        logic [ADDR_W-1:0]  rd_a_addr;
        logic [ADDR_W-1:0]  rd_b_addr;
    } t_ram_req;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UP,
        ST_POP_RD,
        ST_DOWN,
        ST_FRONT_RD,
        ST_FRONT,
        ST_DONE
    } t_state;

    function automatic logic entry_less(input t_entry a, input t_entry b,
                                        input logic [31:0] arrival);
        logic [31:0] age_a;
        logic [31:0] age_b;
        age_a = arrival - a.order;
        age_b = arrival - b.order;
        return (a.prio < b.prio) || ((a.prio == b.prio) && (age_a > age_b));
    endfunction

    function automatic logic [15:0] tag_ext(input logic [TAG_W-1:0] t);
        logic [15:0] r;
        r = '0;
        r[TAG_W-1:0] = t;
        return r;
    endfunction

endpackage

// ===== design/spq_ram.sv =====
`timescale 1ns / 1ps

module spq_ram #(
    parameter int WIDTH  = 80,
    parameter int DEPTH  = 512,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_a_addr,
    output logic [WIDTH-1:0]  o_rd_a_data,
    input  logic [ADDR_W-1:0] i_rd_b_addr,
    output logic [WIDTH-1:0]  o_rd_b_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_a_data;
    logic [WIDTH-1:0] r_rd_b_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_a_data <= r_mem[i_rd_a_addr];
        r_rd_b_data <= r_mem[i_rd_b_addr];
    end

    assign o_rd_a_data = r_rd_a_data;
    assign o_rd_b_data = r_rd_b_data;

endmodule

// ===== design/spq_engine.sv =====
`timescale 1ns / 1ps

module spq_engine
    import spq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_beat  i_in,
    output logic      o_res_valid,
    input  logic      i_res_ready,
    output t_out_beat o_res,
    output t_ram_req  o_ram_req,
    input  t_entry    i_rd_a_data,
    input  t_entry    i_rd_b_data
);

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [31:0]       r_arrival, n_arrival;
    logic [ADDR_W-1:0] r_idx, n_idx;
    t_entry            r_x, n_x;
    logic [1:0]        r_status, n_status;
    logic [15:0]       r_pop_item, n_pop_item;
    logic [31:0]       r_pop_prio, n_pop_prio;
    t_out_beat         r_res, n_res;

    logic               in_fire;
    logic [CNT_W-1:0]   cnt_m1;
    logic [CHILD_W-1:0] child_l;
    logic [CHILD_W-1:0] child_r;
    logic [CHILD_W-1:0] cnt_ext;
    logic               has_l;
    logic               pick_b;
    t_entry             best;
    logic [ADDR_W-1:0]  best_idx;
    logic [ADDR_W:0]    best_child;
    logic               best_lt_x;
    logic [ADDR_W-1:0]  idx_m1;
    logic [ADDR_W-1:0]  parent;
    logic [ADDR_W-1:0]  par_m1;
    logic               x_lt_par;

    assign in_fire    = i_in_valid && o_in_ready;
    assign cnt_m1     = r_count - CNT_W'(1);
    assign child_l    = CHILD_W'({r_idx, 1'b1});
    assign child_r    = child_l + CHILD_W'(1);
    assign cnt_ext    = CHILD_W'(r_count);
    assign has_l      = child_l < cnt_ext;
    assign pick_b     = (child_r < cnt_ext) && entry_less(i_rd_b_data, i_rd_a_data, r_arrival);
    assign best       = pick_b ? i_rd_b_data : i_rd_a_data;
    assign best_idx   = pick_b ? child_r[ADDR_W-1:0] : child_l[ADDR_W-1:0];
    assign best_child = {best_idx, 1'b1};
    assign best_lt_x  = entry_less(best, r_x, r_arrival);
    assign idx_m1     = r_idx - ADDR_W'(1);
    assign parent     = idx_m1 >> 1;
    assign par_m1     = parent - ADDR_W'(1);
    assign x_lt_par   = entry_less(r_x, i_rd_a_data, r_arrival);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_arrival <= '0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_arrival <= n_arrival;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_x        <= n_x;
        r_status   <= n_status;
        r_pop_item <= n_pop_item;
        r_pop_prio <= n_pop_prio;
        r_res      <= n_res;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    if (i_in.kind == KIND_PUSH) begin
                        if (r_count == CNT_W'(CAPACITY)) begin
                            n_state = ST_FRONT;
                        end else if (r_count == '0) begin
                            n_state = ST_FRONT_RD;
                        end else begin
                            n_state = ST_UP;
                        end
                    end else begin
                        n_state = (r_count == '0) ? ST_FRONT : ST_POP_RD;
                    end
                end
            end
            ST_UP: begin
                if (r_idx == '0 || !x_lt_par) begin
                    n_state = ST_FRONT_RD;
                end
            end
            ST_POP_RD: begin
                n_state = (r_count == '0) ? ST_FRONT_RD : ST_DOWN;
            end
            ST_DOWN: begin
                if (!has_l || !best_lt_x) begin
                    n_state = ST_FRONT_RD;
                end
            end
            ST_FRONT_RD: n_state = ST_FRONT;
            ST_FRONT:    n_state = ST_DONE;
            ST_DONE: begin
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_count    = r_count;
        n_arrival  = r_arrival;
        n_idx      = r_idx;
        n_x        = r_x;
        n_status   = r_status;
        n_pop_item = r_pop_item;
        n_pop_prio = r_pop_prio;
        n_res      = r_res;
        o_ram_req  = '0;
        o_in_ready  = 1'b0;
        o_res_valid = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (in_fire) begin
                    n_status   = STAT_OK;
                    n_pop_item = '0;
                    n_pop_prio = '0;
                    if (i_in.kind == KIND_PUSH) begin
                        if (r_count == CNT_W'(CAPACITY)) begin
                            n_status = STAT_FULL;
                        end else begin
                            n_x.prio  = i_in.in_priority;
                            n_x.tag   = i_in.item_tag[TAG_W-1:0];
                            n_x.order = r_arrival;
                            n_arrival = r_arrival + 32'd1;
                            n_count   = r_count + CNT_W'(1);
                            n_idx     = ADDR_W'(r_count);
                            if (r_count == '0) begin
                                o_ram_req.we      = 1'b1;
                                o_ram_req.wr_addr = '0;
                                o_ram_req.wr_data = n_x;
                            end else begin
                                o_ram_req.rd_a_addr = ADDR_W'(cnt_m1 >> 1);
                            end
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = STAT_EMPTY;
                        end else begin
                            o_ram_req.rd_a_addr = '0;
                            o_ram_req.rd_b_addr = ADDR_W'(cnt_m1);
                            n_count             = cnt_m1;
                        end
                    end
                end
            end
            ST_UP: begin
                o_ram_req.we = 1'b1;
                if (r_idx == '0 || !x_lt_par) begin
                    o_ram_req.wr_addr = r_idx;
                    o_ram_req.wr_data = r_x;
                end else begin
                    o_ram_req.wr_addr   = r_idx;
                    o_ram_req.wr_data   = i_rd_a_data;
                    o_ram_req.rd_a_addr = par_m1 >> 1;
                    n_idx               = parent;
                end
            end
            ST_POP_RD: begin
                n_pop_item = tag_ext(i_rd_a_data.tag);
                n_pop_prio = i_rd_a_data.prio;
                n_x        = i_rd_b_data;
                n_idx      = '0;
                if (r_count == '0) begin
                    n_arrival = '0;
                end else begin
                    o_ram_req.rd_a_addr = ADDR_W'(1);
                    o_ram_req.rd_b_addr = ADDR_W'(2 % CAPACITY);
                end
            end
            ST_DOWN: begin
                o_ram_req.we      = 1'b1;
                o_ram_req.wr_addr = r_idx;
                if (!has_l || !best_lt_x) begin
                    o_ram_req.wr_data = r_x;
                end else begin
                    o_ram_req.wr_data   = best;
                    o_ram_req.rd_a_addr = best_child[ADDR_W-1:0];
                    o_ram_req.rd_b_addr = best_child[ADDR_W-1:0] + ADDR_W'(1);
                    n_idx               = best_idx;
                end
            end
            ST_FRONT_RD: begin
                o_ram_req.rd_a_addr = '0;
            end
            ST_FRONT: begin
                n_res.status          = r_status;
                n_res.popped_item     = r_pop_item;
                n_res.popped_priority = r_pop_prio;
                n_res.entry_count     = 10'(r_count);
                if (r_count != '0) begin
                    n_res.front_valid    = 1'b1;
                    n_res.front_item     = tag_ext(i_rd_a_data.tag);
                    n_res.front_priority = i_rd_a_data.prio;
                end else begin
                    n_res.front_valid    = 1'b0;
                    n_res.front_item     = '0;
                    n_res.front_priority = '0;
                end
            end
            ST_DONE: begin
                o_res_valid = 1'b1;
            end
            default: begin
                o_ram_req = '0;
            end
        endcase
    end

    assign o_res = r_res;

endmodule

// ===== design/stable_min_priority_queue.sv =====
`timescale 1ns / 1ps

// Stable min-priority queue of up to CAPACITY tags kept as a binary heap in one
// two-read, one-write entry memory; equal priorities leave in push order. One
// operation (push or pop) is taken at a time. The heap sift moves one level per
// cycle, each cycle a registered memory read and a write-back. A rejected push
// or a pop on an empty queue skips the sift. A finished result waits in an
// output register while the next input beat is taken. The memory needs no
// clearing after reset.
module stable_min_priority_queue
    import spq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_beat  i_in,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out
);

    t_ram_req  ram_req;
    t_entry    rd_a_data;
    t_entry    rd_b_data;
    logic      res_valid;
    logic      res_ready;
    t_out_beat res;

    logic      r_out_valid, n_out_valid;
    t_out_beat r_out, n_out;

    spq_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_ram_req   (ram_req),
        .i_rd_a_data (rd_a_data),
        .i_rd_b_data (rd_b_data)
    );

    spq_ram #(
        .WIDTH  (ENTRY_W),
        .DEPTH  (CAPACITY),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk       (i_clk),
        .i_we        (ram_req.we),
        .i_wr_addr   (ram_req.wr_addr),
        .i_wr_data   (ram_req.wr_data),
        .i_rd_a_addr (ram_req.rd_a_addr),
        .o_rd_a_data (rd_a_data),
        .i_rd_b_addr (ram_req.rd_b_addr),
        .o_rd_b_data (rd_b_data)
    );

    assign res_ready = !r_out_valid || i_out_ready;

    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (res_valid && res_ready) begin
            n_out_valid = 1'b1;
            n_out       = res;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
